// File: src/ptts_pkg.sv
package ptts_pkg;

  localparam int DATA_W    = 32;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 4;
  localparam int OUT_IDX_W = 2;
  localparam int MASK_W    = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL0   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TICK  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 4'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic tick;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic tick_due;
    logic scan_done;
    logic last_out;
    logic out_free;
  } sts_t;

  // a has reached b, wrap-aware
  function automatic logic reached(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] d;
    d = a - b;
    return ~d[DATA_W-1];
  endfunction

endpackage

// File: src/periodic_tick_timer_scheduler.sv
// Channel  Dir  Ports                                    Accept
// in       in   in_valid, in_stall, in_now_time          in_valid && !in_stall
// out      out  out_valid, out_stall, out_fired,         out_valid && !out_stall
//               out_timer_index, out_tick_value,
//               out_more_due, out_last
// cfg      in   cfg_we, cfg_index, cfg_wdata             cfg_we
//
// Steps: accept, tick check, a scan over the timers one by one, and one result
// emit per fired timer (at least one); with no tick due the scan is skipped.
// The scan is set by the single expiry compare shared over timers.
// Reset (synchronous, rst_n low) loads all registers but the sample and
// result payload to defaults: tick 0, deadline 1, expiries 1, no timer enabled.
// A stalled output holds its transaction; the next sample is still taken and
// worked on, and waits only when its first result is ready to load.
module periodic_tick_timer_scheduler import ptts_pkg::*; #(
  parameter int TIMERS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  // time samples
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_now_time,
  // fired-timer reports
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_fired,
  output logic [OUT_IDX_W-1:0] out_timer_index,
  output logic [DATA_W-1:0]    out_tick_value,
  output logic                 out_more_due,
  output logic                 out_last
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: idle -> tick check -> per-timer scan -> result emit
  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tick/deadline counters, expiry table, fired set and output register
  ptts_dp #(
    .TIMERS (TIMERS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_now_time     (in_now_time),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_fired       (out_fired),
    .out_timer_index (out_timer_index),
    .out_tick_value  (out_tick_value),
    .out_more_due    (out_more_due),
    .out_last        (out_last)
  );

endmodule

// File: src/ptts_ctrl.sv
module ptts_ctrl import ptts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_TICK;
      end
      S_TICK: begin
        state_nxt = sts.tick_due ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free && sts.last_out) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_TICK: begin
        cmd.tick = 1'b1;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_to_tick: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_TICK)
    else $error("accepted transaction did not start a tick step");

  a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && !sts.scan_done |=> state_r == S_SCAN)
    else $error("timer scan left early");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && !(sts.out_free && sts.last_out) |=> in_stall)
    else $error("input taken while results still pending");

endmodule

// File: src/ptts_dp.sv
module ptts_dp import ptts_pkg::*; #(
  parameter int TIMERS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic [DATA_W-1:0]    in_now_time,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_fired,
  output logic [OUT_IDX_W-1:0] out_timer_index,
  output logic [DATA_W-1:0]    out_tick_value,
  output logic                 out_more_due,
  output logic                 out_last
);

  localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  logic [TIMERS-1:0] mask_r;
  logic [DATA_W-1:0] interval_r [TIMERS];
  logic [DATA_W-1:0] expiry_r   [TIMERS];
  logic [DATA_W-1:0] start_time_r;
  logic [MS_W-1:0]   ms_r;
  logic [DATA_W-1:0] tick_r;
  logic [DATA_W-1:0] deadline_r;
  logic [DATA_W-1:0] now_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TIMERS-1:0] fire_vec_r;

  logic                 out_valid_r;
  logic                 out_fired_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [DATA_W-1:0]    out_tick_r;
  logic                 out_more_r;
  logic                 out_last_r;

  logic              tick_due;
  logic              cur_hit;
  logic              fire_none;
  logic [IDX_W-1:0]  pick;
  logic [TIMERS-1:0] fire_rest;

  // same compare serves the tick check and, after the tick, more_due
  assign tick_due  = reached(now_r, deadline_r);
  assign cur_hit   = mask_r[idx_r] && reached(tick_r, expiry_r[idx_r]);
  assign fire_none = (fire_vec_r == '0);

  // lowest pending fired timer
  always_comb begin
    pick = '0;
    for (int i = TIMERS - 1; i >= 0; i--) begin
      if (fire_vec_r[i]) pick = IDX_W'(i);
    end
    fire_rest = fire_vec_r;
    fire_rest[pick] = 1'b0;
  end

  assign sts.tick_due  = tick_due;
  assign sts.scan_done = (idx_r == IDX_W'(TIMERS - 1));
  assign sts.last_out  = fire_none || (fire_rest == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= '0;
      start_time_r <= '0;
      ms_r         <= MS_W'(1);
      tick_r       <= '0;
      deadline_r   <= DATA_W'(1);
      idx_r        <= '0;
      fire_vec_r   <= '0;
      for (int i = 0; i < TIMERS; i++) begin
        interval_r[i] <= DATA_W'(1);
        expiry_r[i]   <= DATA_W'(1);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_MASK: mask_r <= cfg_wdata[TIMERS-1:0];
        CFG_START_TICK: begin
          tick_r <= cfg_wdata;
          for (int i = 0; i < TIMERS; i++) begin
            expiry_r[i] <= cfg_wdata + interval_r[i];
          end
        end
        CFG_START_TIME: begin
          start_time_r <= cfg_wdata;
          deadline_r   <= cfg_wdata + DATA_W'(ms_r);
        end
        CFG_MS_PER_TICK: begin
          ms_r       <= cfg_wdata[MS_W-1:0];
          deadline_r <= start_time_r + DATA_W'(cfg_wdata[MS_W-1:0]);
        end
        default: begin
          for (int i = 0; i < TIMERS; i++) begin
            if (cfg_index == CFG_IDX_W'(CFG_INTERVAL0 + i)) begin
              interval_r[i] <= cfg_wdata;
              expiry_r[i]   <= tick_r + cfg_wdata;
            end
          end
        end
      endcase
    end else begin
      if (cmd.accept) begin
        now_r <= in_now_time;
      end
      if (cmd.tick) begin
        idx_r      <= '0;
        fire_vec_r <= '0;
        if (tick_due) begin
          deadline_r <= deadline_r + DATA_W'(ms_r);
          tick_r     <= tick_r + DATA_W'(1);
        end
      end
      if (cmd.scan) begin
        if (cur_hit) begin
          expiry_r[idx_r]   <= tick_r + interval_r[idx_r];
          fire_vec_r[idx_r] <= 1'b1;
        end
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.emit) begin
        fire_vec_r <= fire_none ? fire_vec_r : fire_rest;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_fired_r <= !fire_none;
      out_idx_r   <= fire_none ? '0 : OUT_IDX_W'(pick);
      out_tick_r  <= tick_r;
      out_more_r  <= tick_due;
      out_last_r  <= fire_none || (fire_rest == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_fired       = out_fired_r;
  assign out_timer_index = out_idx_r;
  assign out_tick_value  = out_tick_r;
  assign out_more_due    = out_more_r;
  assign out_last        = out_last_r;

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick && tick_due && !cfg_we |=> tick_r == $past(tick_r) + DATA_W'(1))
    else $error("tick counter did not advance on a due deadline");

  a_emit_drains: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && !fire_none && !cfg_we |=>
      $countones(fire_vec_r) == $countones($past(fire_vec_r)) - 1)
    else $error("result emit did not retire exactly one fired timer");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || !out_stall)
    else $error("result loaded over a stalled transaction");

endmodule

// File: test/tb_periodic_tick_timer_scheduler.sv
`timescale 1ns / 100ps

module tb_periodic_tick_timer_scheduler;
  import ptts_pkg::*;

  localparam int N_TIMERS = 4;

  // one fired-timer report as it leaves the out channel
  typedef struct packed {
    logic                 fired;
    logic [OUT_IDX_W-1:0] timer;
    logic [DATA_W-1:0]    tick;
    logic                 more_due;
    logic                 last;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DATA_W-1:0]    in_now_time = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_fired;
  logic [OUT_IDX_W-1:0] out_timer_index;
  logic [DATA_W-1:0]    out_tick_value;
  logic                 out_more_due;
  logic                 out_last;

  periodic_tick_timer_scheduler #(.TIMERS(N_TIMERS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_now_time     (in_now_time),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_fired       (out_fired),
    .out_timer_index (out_timer_index),
    .out_tick_value  (out_tick_value),
    .out_more_due    (out_more_due),
    .out_last        (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: register copies plus tick/deadline/expiry state
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0] sim_mask;
  logic [DATA_W-1:0] sim_interval [N_TIMERS];
  logic [DATA_W-1:0] sim_start_tick;
  logic [DATA_W-1:0] sim_start_time;
  logic [MS_W-1:0]   sim_ms;
  logic [DATA_W-1:0] sim_tick;
  logic [DATA_W-1:0] sim_deadline;
  logic [DATA_W-1:0] sim_expiry [N_TIMERS];

  report_t           due_reports [$];   // reports owed by the scheduler, oldest first
  logic [DATA_W-1:0] pending_samples [$];
  int                n_queued = 0;
  int                n_taken = 0;
  int                errors = 0;
  bit                calm = 1'b0;       // no gaps, no stalls while set
  bit                in_taken = 1'b0;
  int                gap_left = 0;
  int                stall_left = 0;

  // One time sample: take at most one tick, then fire every enabled timer
  // whose expiry the new tick has reached (signed 32-bit difference).
  function automatic void predict_sample(input logic [DATA_W-1:0] now);
    logic [N_TIMERS-1:0] hits;
    logic [DATA_W-1:0]   diff;
    logic                more;
    report_t             rep;
    hits = '0;
    diff = now - sim_deadline;
    if (!diff[DATA_W-1]) begin
      sim_deadline = sim_deadline + DATA_W'(sim_ms);
      sim_tick     = sim_tick + 1;
      for (int i = 0; i < N_TIMERS; i++) begin
        diff = sim_tick - sim_expiry[i];
        if (sim_mask[i] && !diff[DATA_W-1]) begin
          sim_expiry[i] = sim_tick + sim_interval[i];
          hits[i]       = 1'b1;
        end
      end
    end
    diff = now - sim_deadline;
    more = !diff[DATA_W-1];
    rep.tick     = sim_tick;
    rep.more_due = more;
    if (hits == '0) begin
      rep.fired = 1'b0;
      rep.timer = '0;
      rep.last  = 1'b1;
      due_reports.push_back(rep);
    end else begin
      for (int i = 0; i < N_TIMERS; i++) begin
        if (hits[i]) begin
          rep.fired = 1'b1;
          rep.timer = OUT_IDX_W'(i);
          rep.last  = (hits >> (i + 1)) == '0;
          due_reports.push_back(rep);
        end
      end
    end
  endfunction

  function automatic string fmt_report(input report_t r);
    return $sformatf("fired=%0b idx=%0d tick=%h more=%0b last=%0b",
                     r.fired, r.timer, r.tick, r.more_due, r.last);
  endfunction

  // Idle length: mostly back to back, some short holes, rare long ones.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(1, 3));
    if (r < 96) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 60));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one time-sample transaction at a time, changed at negedge only
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0 || pending_samples.size() == 0) begin
        in_valid    <= 1'b0;
        in_now_time <= $urandom;    // payload is don't-care while idle
        if (gap_left != 0) gap_left--;
      end else begin
        in_valid    <= 1'b1;
        in_now_time <= pending_samples.pop_front();
        gap_left     = pick_gap();
      end
    end
  end

  // receiver back-pressure, independent of out_valid
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall  <= 1'b0;
      stall_left  = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check the out channel first, then predict from the in channel,
  // so one edge never sees its own prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    report_t seen;
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_fired, out_timer_index, out_tick_value, out_more_due, out_last};
      if (due_reports.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t unexpected report: %s", $time, fmt_report(seen));
      end else begin
        want = due_reports.pop_front();
        if (seen.fired !== want.fired || seen.timer !== want.timer ||
            seen.tick !== want.tick || seen.more_due !== want.more_due ||
            seen.last !== want.last) begin
          errors++;
          if (errors <= 40)
            $display("%0t mismatch: expected %s, actual %s",
                     $time, fmt_report(want), fmt_report(seen));
        end
      end
    end
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      n_taken++;
      predict_sample(in_now_time);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Register write; shadow follows at once since the block is idle.
  // Caller is at a negedge and lowers cfg_we after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    int k;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ACTIVE_MASK: sim_mask = val[MASK_W-1:0];
      CFG_START_TICK: begin
        sim_start_tick = val;
        sim_tick       = val;
        for (int i = 0; i < N_TIMERS; i++) sim_expiry[i] = val + sim_interval[i];
      end
      CFG_START_TIME: begin
        sim_start_time = val;
        sim_deadline   = val + DATA_W'(sim_ms);
      end
      CFG_MS_PER_TICK: begin
        sim_ms       = val[MS_W-1:0];
        sim_deadline = sim_start_time + DATA_W'(sim_ms);
      end
      default: begin
        if (idx >= CFG_INTERVAL0 && idx < CFG_INTERVAL0 + N_TIMERS) begin
          k = int'(idx - CFG_INTERVAL0);
          sim_interval[k] = val;
          sim_expiry[k]   = sim_tick + val;
        end
      end
    endcase
    @(negedge clk);
  endtask

  task automatic send(input logic [DATA_W-1:0] now);
    pending_samples.push_back(now);
    n_queued++;
  endtask

  // every sample taken and every report back; called at a negedge
  task automatic drain();
    while (!(n_taken == n_queued && due_reports.size() == 0)) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0]    t;
    logic [DATA_W-1:0]    v;
    logic [CFG_IDX_W-1:0] idx;
    int                   r;
    int                   first;

    // power-on register values
    sim_mask       = '0;
    sim_start_tick = '0;
    sim_start_time = '0;
    sim_ms         = 16'd1;
    sim_tick       = '0;
    sim_deadline   = 32'd1;
    for (int i = 0; i < N_TIMERS; i++) begin
      sim_interval[i] = 32'd1;
      sim_expiry[i]   = 32'd1;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults: nothing enabled, ticks still count
    send(32'd0);
    send(32'd1);
    drain();

    // all timers on, zero interval on timer 3, short tick period
    write_reg(CFG_ACTIVE_MASK, 32'hF);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 0), 32'd1);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 1), 32'd2);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 2), 32'd3);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 3), 32'd0);
    write_reg(CFG_START_TICK, 32'd0);
    write_reg(CFG_START_TIME, 32'd100);
    write_reg(CFG_MS_PER_TICK, 32'd4);
    cfg_we <= 1'b0;
    send(32'd100);
    send(32'd104);
    send(32'd108);
    send(32'd112);
    send(32'd116);
    repeat (5) send(32'd140);        // far past: catch up one tick per sample
    send(32'h8000_0000);
    send(32'h7FFF_FFFF);
    send(32'hFFFF_FFFF);             // behind the deadline by the signed compare
    send(32'd0);
    drain();

    // wrap of tick and time, max interval, frozen deadline
    write_reg(CFG_ACTIVE_MASK, 32'h5);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 0), 32'hFFFF_FFFF);
    write_reg(CFG_IDX_W'(CFG_INTERVAL0 + 2), 32'd1);
    write_reg(CFG_START_TICK, 32'hFFFF_FFFE);
    write_reg(CFG_START_TIME, 32'hFFFF_FFF0);
    write_reg(CFG_MS_PER_TICK, 32'd0);
    cfg_we <= 1'b0;
    send(32'hFFFF_FFEF);
    send(32'hFFFF_FFF0);
    send(32'hFFFF_FFF0);
    send(32'd0);
    send(32'd5);
    send(32'h7FFF_FFEF);
    send(32'h7FFF_FFF0);
    drain();

    // timers 1 and 3 come back with held expiries; longest tick period;
    // a write to an index past the map must leave everything alone
    write_reg(CFG_ACTIVE_MASK, 32'hF);
    write_reg(CFG_MS_PER_TICK, 32'h0000_FFFF);
    write_reg(CFG_START_TIME, 32'h8000_0000);
    write_reg(CFG_IDX_W'(CFG_MS_PER_TICK + 8), 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send(32'h8000_FFFF);
    send(32'h8001_FFFE);
    send(32'hFFFF_FFFF);
    drain();

    // random phases: fresh settings, then a running clock with some noise
    for (int ph = 0; ph < 7; ph++) begin
      calm  = (ph == 2) || ($urandom_range(0, 4) == 0);
      first = $urandom_range(0, 7);
      for (int k = 0; k < 8; k++) begin
        idx = CFG_IDX_W'((first + k) % 8);
        r   = $urandom_range(0, 99);
        case (idx)
          CFG_ACTIVE_MASK: write_reg(idx, DATA_W'($urandom_range(0, 15)));
          CFG_START_TICK: begin
            if (r < 35)
              write_reg(idx, (r < 15) ? 32'hFFFF_FFFF - $urandom_range(0, 8) : $urandom);
          end
          CFG_START_TIME: write_reg(idx, $urandom);
          CFG_MS_PER_TICK: begin
            if (r < 60) v = $urandom_range(1, 8);
            else if (r < 70) v = '0;
            else if (r < 80) v = 32'h0000_FFFF;
            else v = $urandom_range(9, 65535);
            write_reg(idx, v);
          end
          default: begin
            if (r < 75) begin
              r = $urandom_range(0, 99);
              if (r < 70) v = $urandom_range(1, 6);
              else if (r < 80) v = '0;
              else if (r < 90) v = $urandom_range(7, 40);
              else v = $urandom;
              write_reg(idx, v);
            end
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_MS_PER_TICK + CFG_IDX_W'($urandom_range(1, 8)), $urandom);
      cfg_we <= 1'b0;

      t = sim_start_time - $urandom_range(0, 3);
      for (int n = 0; n < 36; n++) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          t = t + $urandom_range(0, 2 * sim_ms + 1);
          send(t);
        end else if (r < 86) begin
          t = t - $urandom_range(0, 3 * sim_ms + 2);   // clock stepped back
          send(t);
        end else if (r < 93) begin
          send(t + $urandom_range(0, 32'h7FFF_FFFF));  // lone sample far ahead
        end else begin
          send($urandom);
        end
      end
      drain();
    end

    calm = 1'b0;
    repeat (24) @(negedge clk);     // room for any stray report
    if (errors == 0 && due_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
src/ptts_pkg.sv
src/ptts_ctrl.sv
src/ptts_dp.sv
src/periodic_tick_timer_scheduler.sv
test/tb_periodic_tick_timer_scheduler.sv
